[src/sps_pkg.sv]
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types, constants and coil tables for the stepper phase sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

    // Command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Register index (address bit 2 selects the register word)
    localparam logic REG_STEPS_PER_REV = 1'b0;

    localparam logic [11:0] STEPS_PER_REV_RESET = 12'd200;

    // Angle divisors and saturated remainder limits (32767 steps)
    localparam int          STEP_SAT  = 32767;
    localparam logic [8:0]  HALF_DIV  = 9'd180;
    localparam logic [8:0]  FULL_DIV  = 9'd360;
    localparam logic [23:0] HALF_LIM  = 24'(STEP_SAT * 180);
    localparam logic [23:0] FULL_LIM  = 24'(STEP_SAT * 360);

    typedef struct packed {
        logic        cmd;
        logic        half_step;
        logic        direction;
        logic [15:0] degrees;
        logic [15:0] step_ticks;
    } req_t;

    typedef struct packed {
        logic [3:0] phases;
        logic       busy_res;
        logic       rejected;
    } res_t;

    typedef struct packed {
        logic [11:0] steps_per_rev;
    } cfg_t;

    function automatic logic [3:0] half_pattern(input logic [2:0] idx);
        logic [3:0] pat;
        case (idx)
            3'd0:    pat = 4'h2;
            3'd1:    pat = 4'h6;
            3'd2:    pat = 4'h4;
            3'd3:    pat = 4'h5;
            3'd4:    pat = 4'h1;
            3'd5:    pat = 4'h9;
            3'd6:    pat = 4'h8;
            3'd7:    pat = 4'hA;
            default: pat = 4'h0;
        endcase
        return pat;
    endfunction

    function automatic logic [3:0] full_pattern(input logic [1:0] idx);
        logic [3:0] pat;
        case (idx)
            2'd0:    pat = 4'h2;
            2'd1:    pat = 4'h4;
            2'd2:    pat = 4'h1;
            2'd3:    pat = 4'h8;
            default: pat = 4'h0;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

[src/sps_apb_regs.sv]
// ----------------------------------------------------------------------------
// sps_apb_regs
// APB register file: holds steps_per_rev.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_apb_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    output sps_pkg::cfg_t      cfg
);
    import sps_pkg::*;

    logic [11:0] spr_reg;
    logic        wr_en;

    // low address bits ignored
    assign wr_en = psel && penable && pwrite && (paddr[2] == REG_STEPS_PER_REV);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spr_reg <= STEPS_PER_REV_RESET;
        end
        else if (wr_en)
        begin
            spr_reg <= pwdata[11:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_STEPS_PER_REV)
        begin
            prdata = {20'd0, spr_reg};
        end
        else
        begin
            prdata = 32'd0;
        end
    end

    assign pready            = 1'b1;
    assign cfg.steps_per_rev = spr_reg;

endmodule

`default_nettype wire

[src/sps_core.sv]
// ----------------------------------------------------------------------------
// sps_core
// Move state and per-request update. Step count is kept as the remaining
// angle product; one step consumes one divisor's worth of it.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          fire,
    input  sps_pkg::req_t      req,
    input  sps_pkg::cfg_t      cfg,
    output sps_pkg::res_t      res
);
    import sps_pkg::*;

    logic [2:0]  phase_index_reg, phase_index_next;
    logic [23:0] rem_reg, rem_next;
    logic [15:0] hold_count_reg, hold_count_next;
    logic [15:0] hold_period_reg, hold_period_next;
    logic        half_reg, half_next;
    logic        rev_reg, rev_next;
    logic        moving_reg, moving_next;
    logic [3:0]  held_reg, held_next;

    logic [27:0] prod;
    logic [8:0]  start_div;
    logic [23:0] start_lim;
    logic [23:0] start_rem;
    logic [15:0] start_period;
    logic [8:0]  move_div;
    logic [23:0] rem_dec;
    logic [15:0] hc_dec;
    logic [2:0]  adv_index;

    assign prod         = 28'(req.degrees) * 28'(cfg.steps_per_rev);
    assign start_div    = req.half_step ? HALF_DIV : FULL_DIV;
    assign start_lim    = req.half_step ? HALF_LIM : FULL_LIM;
    assign start_rem    = (prod > {4'd0, start_lim}) ? start_lim : prod[23:0];
    assign start_period = (req.step_ticks == 16'd0) ? 16'd1 : req.step_ticks;

    assign move_div = half_reg ? HALF_DIV : FULL_DIV;
    assign rem_dec  = rem_reg - {15'd0, move_div};
    assign hc_dec   = hold_count_reg - 16'd1;

    always_comb
    begin
        if (half_reg)
        begin
            adv_index = rev_reg ? (phase_index_reg - 3'd1) : (phase_index_reg + 3'd1);
        end
        else
        begin
            adv_index = {1'b0, rev_reg ? (phase_index_reg[1:0] - 2'd1)
                                       : (phase_index_reg[1:0] + 2'd1)};
        end
    end

    always_comb
    begin
        phase_index_next = phase_index_reg;
        rem_next         = rem_reg;
        hold_count_next  = hold_count_reg;
        hold_period_next = hold_period_reg;
        half_next        = half_reg;
        rev_next         = rev_reg;
        moving_next      = moving_reg;
        held_next        = held_reg;

        if (req.cmd == CMD_START)
        begin
            if (!moving_reg)
            begin
                half_next        = req.half_step;
                rev_next         = req.direction;
                hold_period_next = start_period;
                rem_next         = start_rem;
                if (start_rem >= {15'd0, start_div})
                begin
                    moving_next     = 1'b1;
                    held_next       = req.half_step ? half_pattern(phase_index_reg)
                                                    : full_pattern(phase_index_reg[1:0]);
                    hold_count_next = start_period;
                end
            end
        end
        else if (moving_reg)
        begin
            hold_count_next = hc_dec;
            if (hc_dec == 16'd0)
            begin
                phase_index_next = adv_index;
                rem_next         = rem_dec;
                if (rem_dec < {15'd0, move_div})
                begin
                    moving_next = 1'b0;
                end
                else
                begin
                    held_next       = half_reg ? half_pattern(adv_index)
                                               : full_pattern(adv_index[1:0]);
                    hold_count_next = hold_period_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_index_reg <= 3'd0;
            rem_reg         <= 24'd0;
            hold_count_reg  <= 16'd0;
            hold_period_reg <= 16'd0;
            half_reg        <= 1'b0;
            rev_reg         <= 1'b0;
            moving_reg      <= 1'b0;
            held_reg        <= 4'd0;
        end
        else if (fire)
        begin
            phase_index_reg <= phase_index_next;
            rem_reg         <= rem_next;
            hold_count_reg  <= hold_count_next;
            hold_period_reg <= hold_period_next;
            half_reg        <= half_next;
            rev_reg         <= rev_next;
            moving_reg      <= moving_next;
            held_reg        <= held_next;
        end
    end

    assign res.phases   = held_next;
    assign res.busy_res = moving_next;
    assign res.rejected = (req.cmd == CMD_START) && moving_reg;

endmodule

`default_nettype wire

[src/stepper_phase_sequencer.sv]
// ----------------------------------------------------------------------------
// stepper_phase_sequencer
// Four-coil stepper sequencer with half-step and full-step tables.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall/req_data): each request is a tick
//   (cmd 0) or a move start (cmd 1). Result channel (res_valid/res_stall/
//   res_data): exactly one result per request, in order, giving the coil
//   pattern, busy flag and a reject flag for a start issued while busy.
//   A request moves at an edge where valid is high and stall is low.
// Path: an accepted request passes the input register, then the state
//   update into the result register, which raises res_valid.
// Throughput: 1 request per cycle while results are not stalled; the move
//   state updates in a single pass, the 16x12 angle multiply included.
// Stall: when res_stall holds a full result register, the input register
//   keeps its request and req_stall rises; nothing is dropped.
// Reset: rst_n (async, active low) clears the move state, coils off, idle;
//   steps_per_rev returns to 200. Write it over APB (byte address 0) only
//   while the sequencer is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_phase_sequencer (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // request channel
    input  wire logic          req_valid,
    output logic               req_stall,
    input  sps_pkg::req_t      req_data,
    // result channel
    output logic               res_valid,
    input  wire logic          res_stall,
    output sps_pkg::res_t      res_data,
    // APB configuration
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready
);
    import sps_pkg::*;

    cfg_t cfg;
    req_t s1_req_reg;
    logic s1_valid_reg;
    res_t res_reg;
    logic res_valid_reg;
    res_t core_res;

    logic out_ready;   // result register can take a new value
    logic fire;        // input register's request is processed this cycle
    logic accept;

    assign out_ready = !res_valid_reg || !res_stall;
    assign fire      = s1_valid_reg && out_ready;
    assign req_stall = s1_valid_reg && !out_ready;
    assign accept    = req_valid && !req_stall;

    sps_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sps_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .req   (s1_req_reg),
        .cfg   (cfg),
        .res   (core_res)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= req_data;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= core_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

`default_nettype wire

[src/sps_checker.sv]
// ----------------------------------------------------------------------------
// sps_checker
// Port-level checks for the stepper phase sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          res_valid,
    input  wire logic          res_stall,
    input  sps_pkg::res_t      res_data,
    input  wire logic [31:0]   prdata
);
    import sps_pkg::*;

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // a rejected start leaves the move running
    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.rejected |-> res_data.busy_res)
        else $error("reject reported while idle");

    // only 12 register bits exist
    a_prdata_width: assert property (@(posedge clk) disable iff (!rst_n)
        prdata[31:12] == 20'd0)
        else $error("read data above register width");

endmodule

bind stepper_phase_sequencer sps_checker u_sps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .prdata    (prdata)
);

`default_nettype wire

[tb/sv/stepper_phase_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stepper phase checker
// Watches the request, result and register ports of the sequencer, keeps its
// own copy of the move state, predicts one result per request and compares
// every accepted result field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module stepper_phase_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    input  wire logic        req_stall,
    input  sps_pkg::req_t    req_data,
    input  wire logic        res_valid,
    input  wire logic        res_stall,
    input  sps_pkg::res_t    res_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic [31:0] prdata,
    input  wire logic        pready,
    output int               mismatch_count,
    output int               pending,
    output bit               move_active
);
    import sps_pkg::*;

    // coil tables, entry i in nibble i
    localparam logic [31:0] HALF_SEQ = 32'hA891_5462;
    localparam logic [15:0] FULL_SEQ = 16'h8142;
    localparam logic [2:0]  SPR_ADDR = {REG_STEPS_PER_REV, 2'b00};

    logic [11:0] rev_steps;
    logic [2:0]  coil_idx;
    logic [14:0] steps_left;
    logic [15:0] hold_cnt;
    logic [15:0] hold_len;
    bit          half_mode;
    bit          reverse_mode;
    logic [3:0]  coil_pat;
    res_t        expected_coils [$];
    res_t        want_res;

    function automatic logic [3:0] coil_pattern();
        if (half_mode)
            return HALF_SEQ[4 * coil_idx +: 4];
        return FULL_SEQ[4 * coil_idx[1:0] +: 4];
    endfunction

    // Applies one request to the move state and returns the result it causes.
    function automatic res_t next_coil_state(input req_t r);
        logic [27:0] product;
        logic [27:0] count;
        res_t        out;
        out.rejected = 1'b0;
        if (r.cmd == CMD_START)
        begin
            if (move_active)
            begin
                out.rejected = 1'b1;
            end
            else
            begin
                product = r.degrees * rev_steps;
                count = product / (r.half_step ? HALF_DIV : FULL_DIV);
                if (count > STEP_SAT)
                    count = 28'(STEP_SAT);
                half_mode = r.half_step;
                reverse_mode = r.direction;
                hold_len = (r.step_ticks == 16'd0) ? 16'd1 : r.step_ticks;
                steps_left = count[14:0];
                if (count != 0)
                begin
                    move_active = 1'b1;
                    coil_pat = coil_pattern();
                    hold_cnt = hold_len;
                end
            end
        end
        else if (move_active)
        begin
            hold_cnt = hold_cnt - 16'd1;
            if (hold_cnt == 16'd0)
            begin
                if (half_mode)
                    coil_idx = coil_idx + (reverse_mode ? 3'd7 : 3'd1);
                else
                    coil_idx = {1'b0, coil_idx[1:0] + (reverse_mode ? 2'd3 : 2'd1)};
                steps_left = steps_left - 15'd1;
                if (steps_left == 15'd0)
                begin
                    move_active = 1'b0;
                end
                else
                begin
                    coil_pat = coil_pattern();
                    hold_cnt = hold_len;
                end
            end
        end
        out.phases = coil_pat;
        out.busy_res = move_active;
        return out;
    endfunction

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        mismatch_count++;
        $error("%s: expected %0h, got %0h", name, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rev_steps = STEPS_PER_REV_RESET;
            coil_idx = '0;
            steps_left = '0;
            hold_cnt = '0;
            hold_len = '0;
            half_mode = 1'b0;
            reverse_mode = 1'b0;
            move_active = 1'b0;
            coil_pat = '0;
            expected_coils.delete();
            pending = 0;
        end
        else
        begin
            if (psel && penable && pready && paddr == SPR_ADDR)
            begin
                if (pwrite)
                    rev_steps = pwdata[11:0];
                else if (prdata !== {20'd0, rev_steps})
                    report_field("steps_per_rev", {20'd0, rev_steps}, prdata);
            end

            if (res_valid && !res_stall)
            begin
                if (expected_coils.size() == 0)
                begin
                    mismatch_count++;
                    $error("result %h arrived with no request outstanding", res_data);
                end
                else
                begin
                    want_res = expected_coils.pop_front();
                    if (res_data.phases !== want_res.phases)
                        report_field("phases", 32'(want_res.phases),
                                     32'(res_data.phases));
                    if (res_data.busy_res !== want_res.busy_res)
                        report_field("busy_res", 32'(want_res.busy_res),
                                     32'(res_data.busy_res));
                    if (res_data.rejected !== want_res.rejected)
                        report_field("rejected", 32'(want_res.rejected),
                                     32'(res_data.rejected));
                end
            end

            if (req_valid && !req_stall)
                expected_coils.push_back(next_coil_state(req_data));
            pending = expected_coils.size();
        end
    end

endmodule

[tb/sv/stepper_phase_sequencer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stepper phase sequencer testbench
// Drives tick and move-start requests through the sequencer under random
// sender bursts and receiver stalls, reprograms steps_per_rev between phases,
// and leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------

module stepper_phase_sequencer_tb;
    import sps_pkg::*;

    localparam int HOLD_OFF_CYCLES = 200;  // long receiver hold-off
    localparam int SETTLE_CHUNK    = 16;   // ticks sent between idle checks

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_t        req_data = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    res_t        res_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          mismatch_count;
    int          pending;
    bit          move_active;

    // Handshake between stimulus and receiver for the long hold-off.
    bit          hold_request = 1'b0;
    // Sender burst state; gapless suppresses idle gaps for the overflow burst.
    int          burst_left = 0;
    bit          gapless = 1'b0;
    // Register value currently programmed, used to size short moves.
    int unsigned spr_setting = 32'(STEPS_PER_REV_RESET);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    stepper_phase_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    stepper_phase_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_data       (req_data),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .res_data       (res_data),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .pending        (pending),
        .move_active    (move_active)
    );

    // ------------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------------

    // Tick request: only cmd matters, the rest is noise that must be ignored.
    function automatic req_t tick_req();
        req_t r;
        r.cmd = CMD_TICK;
        r.half_step = 1'($urandom_range(0, 1));
        r.direction = 1'($urandom_range(0, 1));
        r.degrees = 16'($urandom_range(0, 65535));
        r.step_ticks = 16'($urandom_range(0, 65535));
        return r;
    endfunction

    function automatic req_t start_req(input logic half, input logic dir,
                                       input logic [15:0] deg, input logic [15:0] ticks);
        req_t r;
        r.cmd = CMD_START;
        r.half_step = half;
        r.direction = dir;
        r.degrees = deg;
        r.step_ticks = ticks;
        return r;
    endfunction

    // Start sized for a handful of steps (at least one when steps_per_rev is
    // nonzero) with a short hold, so random moves end quickly.
    function automatic req_t short_start();
        logic        half;
        int unsigned span;
        int unsigned want_steps;
        int unsigned deg;
        int unsigned ticks;
        half = 1'($urandom_range(0, 1));
        span = half ? 180 : 360;
        want_steps = $urandom_range(1, 6);
        if (spr_setting == 0)
            deg = $urandom_range(0, 65535);
        else
            deg = (want_steps * span + spr_setting - 1) / spr_setting + $urandom_range(0, 1);
        if ($urandom_range(0, 7) == 0)
            ticks = $urandom_range(4, 12);
        else
            ticks = $urandom_range(0, 3);
        return start_req(half, 1'($urandom_range(0, 1)), 16'(deg), 16'(ticks));
    endfunction

    // Full-range start; only ever sent straight after a short start, so it
    // lands while a move is in progress and gets rejected when steps_per_rev is nonzero.
    function automatic req_t wild_start();
        return start_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    endfunction

    // ------------------------------------------------------------------------
    // Channel and register port drivers
    // ------------------------------------------------------------------------

    // Present one request and hold it until accepted. Valid stays high across
    // a burst; a random gap follows each burst unless gapless is set.
    task automatic send(input req_t r);
        req_valid <= 1'b1;
        req_data <= r;
        do
            @(posedge clk);
        while (req_stall);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0 && !gapless)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
    endtask

    // Stop offering requests until every expected result has come back.
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Keep ticking until the predicted move is over; surplus ticks on an idle
    // sequencer change nothing.
    task automatic settle_move();
        do
        begin
            repeat (SETTLE_CHUNK) send(tick_req());
            wait_drained();
        end
        while (move_active);
    endtask

    // One APB transfer: setup cycle, then access cycle until pready.
    task automatic apb_access(input logic write, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= {REG_STEPS_PER_REV, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Program steps_per_rev and read it back; callers make sure the
    // sequencer is idle first.
    task automatic set_revolution(input logic [11:0] value);
        apb_access(1'b1, {20'd0, value});
        apb_access(1'b0, 32'd0);
        spr_setting = 32'(value);
    endtask

    // ------------------------------------------------------------------------
    // Random phase: mostly ticks, short moves, and start-while-busy pairs.
    // A third of the way in, the receiver holds off while a gapless burst
    // fills the sequencer; two thirds in, the sender waits for every result.
    // ------------------------------------------------------------------------
    task automatic run_random(input int count);
        int k;
        int roll;
        for (k = 0; k < count; k++)
        begin
            if (k == count / 3)
            begin
                hold_request = 1'b1;
                gapless = 1'b1;
                repeat (40) send(tick_req());
                gapless = 1'b0;
            end
            if (k == 2 * count / 3)
                wait_drained();
            roll = $urandom_range(0, 9);
            if (roll < 7)
            begin
                send(tick_req());
            end
            else if (roll < 9)
            begin
                send(short_start());
            end
            else
            begin
                send(short_start());
                send(wild_start());
            end
        end
        settle_move();
    endtask

    // ------------------------------------------------------------------------
    // Receiver: alternating short stalls and free runs, occasional long free
    // stretches, and the long hold-off when the stimulus asks for it.
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int run_left;
        int roll;
        bit stall_now;
        run_left = 0;
        stall_now = 1'b0;
        forever
        begin
            @(posedge clk);
            if (run_left == 0)
            begin
                roll = $urandom_range(0, 9);
                if (hold_request)
                begin
                    hold_request = 1'b0;
                    stall_now = 1'b1;
                    run_left = HOLD_OFF_CYCLES;
                end
                else if (roll < 2)
                begin
                    stall_now = 1'b0;
                    run_left = $urandom_range(16, 48);
                end
                else if (stall_now)
                begin
                    stall_now = 1'b0;
                    run_left = $urandom_range(1, 6);
                end
                else
                begin
                    stall_now = 1'b1;
                    run_left = $urandom_range(1, 4);
                end
            end
            res_stall <= stall_now;
            run_left--;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, steps_per_rev at its reset value of 200.
        send(tick_req());                              // tick while idle
        send(start_req(1'b1, 1'b0, 16'd0, 16'd0));     // zero-step start
        send(start_req(1'b1, 1'b0, 16'd1, 16'd0));     // one half step, period 0 as 1
        send(tick_req());
        send(tick_req());
        send(start_req(1'b1, 1'b0, 16'd9, 16'd2));     // ten half steps
        send(start_req(1'b1, 1'b1, 16'hFFFF, 16'hFFFF)); // start while busy
        settle_move();
        send(start_req(1'b0, 1'b1, 16'd9, 16'd1));     // full step backward from odd index
        settle_move();
        send(start_req(1'b1, 1'b1, 16'd5, 16'd0));     // half step backward, wraps
        settle_move();
        send(start_req(1'b0, 1'b0, 16'd2, 16'd150));   // one step held for a long period
        settle_move();
        run_random(200);

        // Largest register value: widest angle product.
        set_revolution(12'd4095);
        send(start_req(1'b1, 1'b0, 16'd2, 16'd1));
        settle_move();
        run_random(150);

        // Zero steps_per_rev: every start is a zero-step start.
        set_revolution(12'd0);
        send(start_req(1'b1, 1'b0, 16'hFFFF, 16'hFFFF));
        send(start_req(1'b0, 1'b1, 16'hFFFF, 16'd0));
        send(tick_req());
        run_random(60);

        set_revolution(12'd1);
        run_random(180);

        set_revolution(12'($urandom_range(2, 4094)));
        run_random(180);

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("stepper_phase_sequencer: match");
        else
            $display("stepper_phase_sequencer: mismatch");
        $finish;
    end

    // Hard stop well beyond the slowest legitimate run.
    initial
    begin : watchdog
        #40_000_000;
        $display("stepper_phase_sequencer: mismatch");
        $finish;
    end

endmodule
